>>> hdl/c8x_pkg.sv
// Shared types and constants of the CHIP-8 instruction execute block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package c8x_pkg;

    // Return stack depth and the widths that follow from it.
    localparam int STACK_DEPTH = 16;
    localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int ADDR_W = 12;
    localparam int INSTR_W = 16;
    localparam int VREG_W = 8;
    localparam int VNUM_W = 4;

    localparam logic [ADDR_W-1:0] ENTRY_RESET = 12'h200;
    localparam logic [VNUM_W-1:0] VF_NUM      = 4'hF;

    // Major opcodes (top nibble of the instruction).
    localparam logic [3:0] OP_JUMP   = 4'h1;
    localparam logic [3:0] OP_CALL   = 4'h2;
    localparam logic [3:0] OP_SEQ_NN = 4'h3;
    localparam logic [3:0] OP_SNE_NN = 4'h4;
    localparam logic [3:0] OP_SEQ_VY = 4'h5;
    localparam logic [3:0] OP_LOAD   = 4'h6;
    localparam logic [3:0] OP_ADD_NN = 4'h7;
    localparam logic [3:0] OP_ALU    = 4'h8;
    localparam logic [3:0] OP_SET_I  = 4'hA;

    // ALU sub-operations (low nibble of 8XYN).
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNIMPL   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Write request into the V register memory.
    typedef struct packed {
        logic              en;
        logic [VNUM_W-1:0] addr;
        logic [VREG_W-1:0] data;
    } t_vwr;

    // Outcome of executing one instruction.
    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] index_value;
        logic              reg_written;
        logic [VNUM_W-1:0] reg_number;
        logic [VREG_W-1:0] reg_value;
        logic              flag_written;
        logic              flag_value;
        t_status           status;
        logic              push;
    } t_exec;

endpackage

`default_nettype wire

>>> hdl/chip8_instruction_execute.sv
// Top level of the CHIP-8 instruction execute block.
// Depends on c8x_pkg, c8x_regfile, c8x_stack and c8x_exec.
`timescale 1ns / 1ps
`default_nettype none

// Channel       Direction  Handshake                 Payload
// instruction   in         i_valid / o_stall         i_instruction
// result        out        o_valid / i_stall         o_next_pc ... o_status
// config        in         i_cfg_valid / o_cfg_ready i_cfg_data (entry address)
//
// For each instruction, the acceptance edge issues the VX and VY reads to the
// register memory, and the edge at which the execute stage fires executes,
// writes back and loads the result register. A new instruction is accepted
// every cycle unless a result stall holds it back; the read-after-write case
// is served by the memory's bypass of its latest write. Reset is synchronous
// and active low; it clears the pointer, the index and the register valid
// bits and returns the entry address to its default of 0x200, and the program
// counter takes the entry address as it leaves reset. A stall on the result
// side holds the executing instruction, which in turn stalls input.

module chip8_instruction_execute (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Instruction channel.
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [c8x_pkg::INSTR_W-1:0] i_instruction,
    // Result channel.
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [c8x_pkg::ADDR_W-1:0]  o_next_pc,
    output logic      [c8x_pkg::ADDR_W-1:0]  o_index_value,
    output logic                             o_reg_written,
    output logic      [c8x_pkg::VNUM_W-1:0]  o_reg_number,
    output logic      [c8x_pkg::VREG_W-1:0]  o_reg_value,
    output logic                             o_flag_written,
    output logic                             o_flag_value,
    output logic      [1:0]                  o_status,
    // Configuration channel.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [c8x_pkg::ADDR_W-1:0]  i_cfg_data
);
    import c8x_pkg::*;

    // Handshake terms.
    logic accept;
    logic s1_adv;
    logic s1_fire;

    // Architectural state kept in flip-flops.
    logic [ADDR_W-1:0] r_entry;
    logic              r_boot;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_index;
    logic [VREG_W-1:0] r_vf;

    // Execute stage.
    logic               r_s1_valid;
    logic [INSTR_W-1:0] r_s1_instr;
    logic [VREG_W-1:0]  mem_vx;
    logic [VREG_W-1:0]  mem_vy;
    logic [VREG_W-1:0]  vx;
    logic [VREG_W-1:0]  vy;
    logic               stack_full;
    t_exec              res;
    t_vwr               vwr;
    logic [VNUM_W-1:0]  s1_x;
    logic [VNUM_W-1:0]  s1_y;

    // Result register.
    logic r_out_valid;
    t_exec r_out;

    assign o_cfg_ready = 1'b1;

    // The execute stage moves on whenever the result register can take it.
    assign s1_adv  = !r_out_valid || !i_stall;
    assign s1_fire = r_s1_valid && s1_adv;
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    assign s1_x = r_s1_instr[11:8];
    assign s1_y = r_s1_instr[7:4];

    // VF lives in a flip-flop so a flag op can update it alongside VX.
    assign vx = (s1_x == VF_NUM) ? r_vf : mem_vx;
    assign vy = (s1_y == VF_NUM) ? r_vf : mem_vy;

    c8x_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_rd_x  (i_instruction[11:8]),
        .i_rd_y  (i_instruction[7:4]),
        .i_wr    (vwr),
        .o_vx    (mem_vx),
        .o_vy    (mem_vy)
    );

    c8x_stack u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s1_fire && res.push),
        .i_push_addr (r_pc),
        .o_full      (stack_full)
    );

    c8x_exec u_exec (
        .i_instr      (r_s1_instr),
        .i_vx         (vx),
        .i_vy         (vy),
        .i_pc         (r_pc),
        .i_index      (r_index),
        .i_stack_full (stack_full),
        .o_res        (res)
    );

    // Writes of V0..VE go to the memory; writes of VF stay in r_vf.
    always_comb begin
        vwr.en   = s1_fire && res.reg_written && (s1_x != VF_NUM);
        vwr.addr = s1_x;
        vwr.data = res.reg_value;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_instr <= i_instruction;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The entry address only matters at reset; the counter loads it once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= ENTRY_RESET;
            r_boot  <= 1'b1;
            r_pc    <= ENTRY_RESET;
            r_index <= '0;
            r_vf    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry <= i_cfg_data;
            end
            if (r_boot) begin
                r_boot <= 1'b0;
                r_pc   <= r_entry;
            end else if (s1_fire) begin
                r_pc <= res.next_pc;
            end
            if (s1_fire) begin
                r_index <= res.index_value;
                // A write of VF as the destination overrides the flag.
                if (res.reg_written && (s1_x == VF_NUM)) begin
                    r_vf <= res.reg_value;
                end else if (res.flag_written) begin
                    r_vf <= {{(VREG_W-1){1'b0}}, res.flag_value};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_pc      = r_out.next_pc;
    assign o_index_value  = r_out.index_value;
    assign o_reg_written  = r_out.reg_written;
    assign o_reg_number   = r_out.reg_number;
    assign o_reg_value    = r_out.reg_value;
    assign o_flag_written = r_out.flag_written;
    assign o_flag_value   = r_out.flag_value;
    assign o_status       = r_out.status;

endmodule

`default_nettype wire

>>> hdl/c8x_regfile.sv
// V0..VE register memory: two synchronous read ports, one write port,
// reset-cleared valid bits and a bypass of the latest write. Uses c8x_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c8x_regfile (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [c8x_pkg::VNUM_W-1:0] i_rd_x,
    input  wire logic [c8x_pkg::VNUM_W-1:0] i_rd_y,
    input  wire c8x_pkg::t_vwr             i_wr,
    output logic      [c8x_pkg::VREG_W-1:0] o_vx,
    output logic      [c8x_pkg::VREG_W-1:0] o_vy
);
    import c8x_pkg::*;

    localparam int DEPTH = 1 << VNUM_W;

    logic [VREG_W-1:0] r_mem [DEPTH];
    logic [VREG_W-1:0] r_rd_x_data;
    logic [VREG_W-1:0] r_rd_y_data;
    logic [VNUM_W-1:0] r_addr_x;
    logic [VNUM_W-1:0] r_addr_y;
    logic [DEPTH-1:0]  r_vld;
    logic              r_fwd_vld;
    logic [VNUM_W-1:0] r_fwd_addr;
    logic [VREG_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_x_data <= r_mem[i_rd_x];
            r_rd_y_data <= r_mem[i_rd_y];
            r_addr_x    <= i_rd_x;
            r_addr_y    <= i_rd_y;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
            r_fwd_vld        <= 1'b1;
        end
    end

    // The latest write always wins; it covers a write made at the read edge.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_addr_x)) begin
            o_vx = r_fwd_data;
        end else if (r_vld[r_addr_x]) begin
            o_vx = r_rd_x_data;
        end else begin
            o_vx = '0;
        end
        if (r_fwd_vld && (r_fwd_addr == r_addr_y)) begin
            o_vy = r_fwd_data;
        end else if (r_vld[r_addr_y]) begin
            o_vy = r_rd_y_data;
        end else begin
            o_vy = '0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/c8x_stack.sv
// Return stack memory and stack pointer of the execute block.
// Uses c8x_pkg for the depth and address widths.
`timescale 1ns / 1ps
`default_nettype none

module c8x_stack (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [c8x_pkg::ADDR_W-1:0] i_push_addr,
    output logic                           o_full
);
    import c8x_pkg::*;

    logic [ADDR_W-1:0] r_stack [STACK_DEPTH];
    logic [SP_W-1:0]   r_sp;

    assign o_full = (r_sp >= SP_W'(STACK_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_stack[r_sp[STK_IDX_W-1:0]] <= i_push_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_push) begin
            r_sp <= r_sp + SP_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> hdl/c8x_exec.sv
// Combinational execute step: decodes one instruction against its operands.
// Uses c8x_pkg for opcodes, status codes and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module c8x_exec (
    input  wire logic [c8x_pkg::INSTR_W-1:0] i_instr,
    input  wire logic [c8x_pkg::VREG_W-1:0]  i_vx,
    input  wire logic [c8x_pkg::VREG_W-1:0]  i_vy,
    input  wire logic [c8x_pkg::ADDR_W-1:0]  i_pc,
    input  wire logic [c8x_pkg::ADDR_W-1:0]  i_index,
    input  wire logic                        i_stack_full,
    output c8x_pkg::t_exec                   o_res
);
    import c8x_pkg::*;

    logic [3:0]        op;
    logic [3:0]        sub;
    logic [7:0]        nn;
    logic [ADDR_W-1:0] nnn;
    logic [ADDR_W-1:0] pc_2;
    logic [ADDR_W-1:0] pc_4;
    logic [VREG_W:0]   sum;
    logic [VREG_W-1:0] diff;

    assign op   = i_instr[15:12];
    assign sub  = i_instr[3:0];
    assign nn   = i_instr[7:0];
    assign nnn  = i_instr[11:0];
    assign pc_2 = i_pc + ADDR_W'(2);
    assign pc_4 = i_pc + ADDR_W'(4);
    assign sum  = {1'b0, i_vx} + {1'b0, i_vy};
    assign diff = i_vx - i_vy;

    always_comb begin
        o_res              = '0;
        o_res.next_pc      = i_pc;
        o_res.index_value  = i_index;
        o_res.status       = ST_OK;
        unique case (op)
            OP_JUMP: begin
                o_res.next_pc = nnn;
            end
            OP_CALL: begin
                if (i_stack_full) begin
                    o_res.status = ST_OVERFLOW;
                end else begin
                    o_res.push    = 1'b1;
                    o_res.next_pc = nnn;
                end
            end
            OP_SEQ_NN: o_res.next_pc = (i_vx == nn) ? pc_4 : pc_2;
            OP_SNE_NN: o_res.next_pc = (i_vx != nn) ? pc_4 : pc_2;
            OP_SEQ_VY: o_res.next_pc = (i_vx == i_vy) ? pc_4 : pc_2;
            OP_LOAD: begin
                o_res.reg_written = 1'b1;
                o_res.reg_value   = nn;
                o_res.next_pc     = pc_2;
            end
            OP_ADD_NN: begin
                o_res.reg_written = 1'b1;
                o_res.reg_value   = i_vx + nn;
                o_res.next_pc     = pc_2;
            end
            OP_ALU: begin
                o_res.next_pc     = pc_2;
                o_res.reg_written = 1'b1;
                unique case (sub)
                    ALU_MOV: o_res.reg_value = i_vy;
                    ALU_OR:  o_res.reg_value = i_vx | i_vy;
                    ALU_AND: o_res.reg_value = i_vx & i_vy;
                    ALU_XOR: o_res.reg_value = i_vx ^ i_vy;
                    ALU_ADD: begin
                        o_res.reg_value    = sum[VREG_W-1:0];
                        o_res.flag_written = 1'b1;
                        o_res.flag_value   = sum[VREG_W];
                    end
                    ALU_SUB: begin
                        o_res.reg_value    = diff;
                        o_res.flag_written = 1'b1;
                        o_res.flag_value   = (i_vx >= i_vy);
                    end
                    default: begin
                        o_res.reg_written = 1'b0;
                        o_res.next_pc     = i_pc;
                        o_res.status      = ST_UNIMPL;
                    end
                endcase
            end
            OP_SET_I: begin
                o_res.index_value = nnn;
                o_res.next_pc     = pc_2;
            end
            default: o_res.status = ST_UNIMPL;
        endcase
        // The register number is reported only when a register is written.
        if (o_res.reg_written) begin
            o_res.reg_number = i_instr[11:8];
        end
    end

endmodule

`default_nettype wire

>>> tb/chip8_execute_checker.sv
// Checker for the CHIP-8 instruction execute block: watches the instruction,
// result and configuration channels, predicts each result and compares it.
// Depends on c8x_pkg for widths, opcodes and status codes.
`timescale 1ns / 1ps

module chip8_execute_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_instr_valid,
    input  logic                        i_instr_stall,
    input  logic [c8x_pkg::INSTR_W-1:0] i_instruction,
    input  logic                        i_result_valid,
    input  logic                        i_result_stall,
    input  logic [c8x_pkg::ADDR_W-1:0]  i_next_pc,
    input  logic [c8x_pkg::ADDR_W-1:0]  i_index_value,
    input  logic                        i_reg_written,
    input  logic [c8x_pkg::VNUM_W-1:0]  i_reg_number,
    input  logic [c8x_pkg::VREG_W-1:0]  i_reg_value,
    input  logic                        i_flag_written,
    input  logic                        i_flag_value,
    input  logic [1:0]                  i_status,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [c8x_pkg::ADDR_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending_count
);
    import c8x_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] index_value;
        logic              reg_written;
        logic [VNUM_W-1:0] reg_number;
        logic [VREG_W-1:0] reg_value;
        logic              flag_written;
        logic              flag_value;
        t_status           status;
    } t_outcome;

    // Machine state as the block should hold it.
    logic [ADDR_W-1:0] entry_address;
    logic [ADDR_W-1:0] program_counter;
    logic [ADDR_W-1:0] index_register;
    logic [VREG_W-1:0] v_regs [16];
    logic [ADDR_W-1:0] call_stack [STACK_DEPTH];
    int                stack_depth_used;

    t_outcome predicted_outcomes [$];
    t_outcome oldest;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    // Executes one opcode against the state and returns what the block reports.
    function automatic t_outcome execute_instruction(input logic [INSTR_W-1:0] word);
        logic [3:0]        major;
        logic [3:0]        x;
        logic [3:0]        y;
        logic [3:0]        sub;
        logic [7:0]        nn;
        logic [ADDR_W-1:0] nnn;
        logic [7:0]        vx;
        logic [7:0]        vy;
        logic [8:0]        sum;
        logic [ADDR_W-1:0] pc_next;
        t_outcome          r;
        major   = word[15:12];
        x       = word[11:8];
        y       = word[7:4];
        sub     = word[3:0];
        nn      = word[7:0];
        nnn     = word[11:0];
        vx      = v_regs[x];
        vy      = v_regs[y];
        pc_next = program_counter;
        r       = '0;
        r.status = ST_OK;
        case (major)
            OP_JUMP: pc_next = nnn;
            OP_CALL: begin
                if (stack_depth_used >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    call_stack[stack_depth_used] = program_counter;
                    stack_depth_used++;
                    pc_next = nnn;
                end
            end
            OP_SEQ_NN: pc_next = program_counter + ((vx == nn) ? 12'd4 : 12'd2);
            OP_SNE_NN: pc_next = program_counter + ((vx != nn) ? 12'd4 : 12'd2);
            OP_SEQ_VY: pc_next = program_counter + ((vx == vy) ? 12'd4 : 12'd2);
            OP_LOAD: begin
                r.reg_written = 1'b1;
                r.reg_value   = nn;
                pc_next       = program_counter + 12'd2;
            end
            OP_ADD_NN: begin
                r.reg_written = 1'b1;
                r.reg_value   = vx + nn;
                pc_next       = program_counter + 12'd2;
            end
            OP_ALU: begin
                r.reg_written = 1'b1;
                case (sub)
                    ALU_MOV: r.reg_value = vy;
                    ALU_OR:  r.reg_value = vx | vy;
                    ALU_AND: r.reg_value = vx & vy;
                    ALU_XOR: r.reg_value = vx ^ vy;
                    ALU_ADD: begin
                        sum            = {1'b0, vx} + {1'b0, vy};
                        r.reg_value    = sum[7:0];
                        r.flag_written = 1'b1;
                        r.flag_value   = sum[8];
                    end
                    ALU_SUB: begin
                        r.reg_value    = vx - vy;
                        r.flag_written = 1'b1;
                        r.flag_value   = (vx >= vy);
                    end
                    default: begin
                        r.reg_written = 1'b0;
                        r.status      = ST_UNIMPL;
                    end
                endcase
                if (r.status == ST_OK) pc_next = program_counter + 12'd2;
            end
            OP_SET_I: begin
                index_register = nnn;
                pc_next        = program_counter + 12'd2;
            end
            default: r.status = ST_UNIMPL;
        endcase
        program_counter = pc_next;
        // The flag lands in VF first, so a result aimed at VF wins.
        if (r.flag_written) v_regs[VF_NUM] = {7'd0, r.flag_value};
        if (r.reg_written) begin
            v_regs[x]    = r.reg_value;
            r.reg_number = x;
        end
        r.next_pc     = program_counter;
        r.index_value = index_register;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_address   = ENTRY_RESET;
            program_counter = entry_address;
            index_register  = '0;
            foreach (v_regs[i]) v_regs[i] = '0;
            stack_depth_used = 0;
            predicted_outcomes.delete();
        end else begin
            // Results are checked before new requests are predicted, so a
            // result can never be matched against its own request.
            if (i_result_valid && !i_result_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("result arrived with no instruction outstanding");
                    o_fail_count++;
                end else begin
                    oldest = predicted_outcomes.pop_front();
                    compare_field("next_pc", 16'(oldest.next_pc), 16'(i_next_pc));
                    compare_field("index_value", 16'(oldest.index_value),
                                  16'(i_index_value));
                    compare_field("reg_written", 16'(oldest.reg_written),
                                  16'(i_reg_written));
                    compare_field("reg_number", 16'(oldest.reg_number),
                                  16'(i_reg_number));
                    compare_field("reg_value", 16'(oldest.reg_value), 16'(i_reg_value));
                    compare_field("flag_written", 16'(oldest.flag_written),
                                  16'(i_flag_written));
                    compare_field("flag_value", 16'(oldest.flag_value),
                                  16'(i_flag_value));
                    compare_field("status", 16'(oldest.status), 16'(i_status));
                end
            end
            if (i_instr_valid && !i_instr_stall)
                predicted_outcomes.push_back(execute_instruction(i_instruction));
            // The entry address only matters at a reset, which never recurs.
            if (i_cfg_valid && i_cfg_ready) entry_address = i_cfg_data;
        end
        o_pending_count <= predicted_outcomes.size();
    end

endmodule

>>> tb/chip8_instruction_execute_test.sv
// Top of the testbench for the CHIP-8 instruction execute block: clock, reset,
// stimulus and verdict. Depends on c8x_pkg, the block and chip8_execute_checker.
`timescale 1ns / 1ps

module chip8_instruction_execute_test;
    import c8x_pkg::*;

    // Pause that lets the pipeline settle, with margin, before a register write
    // or the verdict.
    localparam int SETTLE_CYCLES = 6;
    // Random requests in each of the four idling phases.
    localparam int PHASE_ITEMS = 281;

    // Opcodes that the block treats as unimplemented.
    localparam logic [INSTR_W-1:0] OPC_CLEAR_SCREEN = 16'h00E0;
    localparam logic [INSTR_W-1:0] OPC_RETURN       = 16'h00EE;
    localparam logic [3:0]         ALU_SHIFT_RIGHT  = 4'h6;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [INSTR_W-1:0] i_instruction  = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [ADDR_W-1:0]  o_next_pc;
    logic [ADDR_W-1:0]  o_index_value;
    logic               o_reg_written;
    logic [VNUM_W-1:0]  o_reg_number;
    logic [VREG_W-1:0]  o_reg_value;
    logic               o_flag_written;
    logic               o_flag_value;
    logic [1:0]         o_status;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [ADDR_W-1:0]  i_cfg_data     = '0;

    int fail_count;
    int pending_count;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    always #2 i_clk = ~i_clk;

    chip8_instruction_execute dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_instruction  (i_instruction),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_pc      (o_next_pc),
        .o_index_value  (o_index_value),
        .o_reg_written  (o_reg_written),
        .o_reg_number   (o_reg_number),
        .o_reg_value    (o_reg_value),
        .o_flag_written (o_flag_written),
        .o_flag_value   (o_flag_value),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    chip8_execute_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_instr_valid   (i_valid),
        .i_instr_stall   (o_stall),
        .i_instruction   (i_instruction),
        .i_result_valid  (o_valid),
        .i_result_stall  (i_stall),
        .i_next_pc       (o_next_pc),
        .i_index_value   (o_index_value),
        .i_reg_written   (o_reg_written),
        .i_reg_number    (o_reg_number),
        .i_reg_value     (o_reg_value),
        .i_flag_written  (o_flag_written),
        .i_flag_value    (o_flag_value),
        .i_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // The result side stalls at random, independently of everything else, at
    // the rate set for the current phase.
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Presents one request and returns at the edge that accepts it. Idle
    // cycles are inserted first at the current phase's rate. Valid is only
    // lowered in idle cycles, so back-to-back requests keep it high without
    // a second assignment in the same step.
    task automatic send_instruction(input logic [INSTR_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_instruction <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // Stops sending and waits until every predicted result has been seen,
    // then lets the pipeline settle. A result that never arrives is caught
    // by the run limit below.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the entry address while the block is idle. It is only loaded on
    // leaving reset, so the write must leave the running program untouched.
    task automatic write_entry_address(input logic [ADDR_W-1:0] addr);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one random request or a short well-formed sequence. Skips only
    // take the interesting branch when the register holds a known value, so
    // most skips follow a load that sets up a hit or a miss. Calls are
    // kept rare so the return stack fills up part way through the run and
    // the overflow case is then exercised for the rest of it.
    task automatic send_random_group();
        int         pick;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] sub;
        logic [7:0] nn;
        logic [7:0] nn_other;
        pick     = $urandom_range(99);
        x        = 4'($urandom_range(15));
        y        = 4'($urandom_range(15));
        nn       = 8'($urandom_range(255));
        nn_other = 8'($urandom_range(255));
        if (pick < 8) begin
            // Pure noise covers every opcode bit and the unimplemented space.
            send_instruction(16'($urandom_range(16'hFFFF)));
        end else if (pick < 12) begin
            send_instruction({OP_CALL, 12'($urandom_range(12'hFFF))});
        end else if (pick < 22) begin
            send_instruction({OP_LOAD, x, nn});
            if ($urandom_range(1)) nn_other = nn;
            send_instruction({($urandom_range(1) ? OP_SEQ_NN : OP_SNE_NN), x, nn_other});
        end else if (pick < 30) begin
            send_instruction({OP_LOAD, x, nn});
            send_instruction({OP_LOAD, y, ($urandom_range(2) != 0) ? nn : nn_other});
            send_instruction({OP_SEQ_VY, x, y, 4'($urandom_range(15))});
        end else if (pick < 55) begin
            // Mostly the six implemented ALU ops, now and then an unused one.
            if ($urandom_range(9) == 0) sub = 4'($urandom_range(ALU_SHIFT_RIGHT, 15));
            else sub = 4'($urandom_range(ALU_SUB));
            send_instruction({OP_ALU, x, y, sub});
        end else if (pick < 70) begin
            send_instruction({OP_LOAD, x, nn});
        end else if (pick < 78) begin
            send_instruction({OP_ADD_NN, x, nn});
        end else if (pick < 86) begin
            send_instruction({OP_SET_I, 12'($urandom_range(12'hFFF))});
        end else if (pick < 92) begin
            send_instruction({OP_JUMP, 12'($urandom_range(12'hFFF))});
        end else begin
            send_instruction({($urandom_range(1) ? OP_SEQ_NN : OP_SNE_NN), x, nn});
        end
    endtask

    // Directed opening: carry and borrow, an ALU op aimed at VF, every ALU
    // op, immediate add wrap, skip hits and misses, the 5XYN form with a
    // nonzero low nibble, index extremes, program counter wrap past the top
    // of memory, a call and the unimplemented opcodes.
    logic [INSTR_W-1:0] directed_program [$] = '{
        {OP_LOAD, 4'h0, 8'hFF},
        {OP_LOAD, 4'h1, 8'h01},
        {OP_ALU, 4'h0, 4'h1, ALU_ADD},
        {OP_ALU, 4'h0, 4'h1, ALU_SUB},
        {OP_ALU, 4'hF, 4'h1, ALU_ADD},
        {OP_ALU, 4'h1, 4'hF, ALU_SUB},
        {OP_ALU, 4'h2, 4'h0, ALU_MOV},
        {OP_ALU, 4'h2, 4'h1, ALU_OR},
        {OP_ALU, 4'h2, 4'h0, ALU_AND},
        {OP_ALU, 4'h2, 4'h1, ALU_XOR},
        {OP_ADD_NN, 4'hE, 8'hFF},
        {OP_ADD_NN, 4'h0, 8'h01},
        {OP_LOAD, 4'h3, 8'h5A},
        {OP_SEQ_NN, 4'h3, 8'h5A},
        {OP_SNE_NN, 4'h3, 8'h5A},
        {OP_SNE_NN, 4'h3, 8'hA5},
        {OP_SEQ_VY, 4'h3, 4'h3, 4'hF},
        {OP_SET_I, 12'hFFF},
        {OP_SET_I, 12'h000},
        {OP_JUMP, 12'hFFE},
        {OP_SEQ_NN, 4'h3, 8'h5A},
        {OP_CALL, 12'h300},
        OPC_CLEAR_SCREEN,
        OPC_RETURN,
        {OP_ALU, 4'h0, 4'h1, ALU_SHIFT_RIGHT},
        {4'hF, 12'hFFF}
    };

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Highest entry address first; the program counter must stay at its
        // reset value since no further reset follows.
        write_entry_address(12'hFFF);
        foreach (directed_program[i]) send_instruction(directed_program[i]);

        // Four phases: no idling, sender idle most cycles, receiver stalling
        // most cycles, and light idling on both sides. The entry address is
        // rewritten between phases once the pipeline is empty.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default: begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            while (sent_count < directed_program.size() + (phase + 1) * PHASE_ITEMS)
                send_random_group();
            drain_pipeline();
            case (phase)
                0: write_entry_address(12'h000);
                1: write_entry_address(12'($urandom_range(12'hFFF)));
                2: write_entry_address(ENTRY_RESET);
                default: ;
            endcase
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/c8x_pkg.sv
hdl/c8x_regfile.sv
hdl/c8x_stack.sv
hdl/c8x_exec.sv
hdl/chip8_instruction_execute.sv
tb/chip8_execute_checker.sv
tb/chip8_instruction_execute_test.sv
